>>> rtl/vmr_pkg.sv
// Shared widths, codes and the controller state type of the vibration magnitude RMS core.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package vmr_pkg;

    // Field widths
    localparam int ACCEL_W    = 16;
    localparam int OFFSET_W   = 20;
    localparam int MAG_W      = 21;
    localparam int DIFF_W     = 21;
    localparam int ENERGY_W   = 42;
    localparam int SUM_W      = 46;

    // Digit-serial square root: two radicand bits per step
    localparam int RAD_W      = 46;
    localparam int ROOT_W     = RAD_W / 2;

    // Digit-serial squaring: four multiplier bits per step
    localparam int DIGIT_W    = 4;
    localparam int MUL_STEPS  = (DIFF_W + DIGIT_W - 1) / DIGIT_W;
    localparam int MUL_W      = MUL_STEPS * DIGIT_W;
    localparam int ACC_W      = DIFF_W + MUL_W;

    localparam int STEP_W     = 6;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_FLOOR = 2'd3;

    localparam logic [MAG_W-1:0] NOISE_FLOOR_RESET = 21'd123;

    localparam int WINDOW_DEFAULT = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_ACC,
        ST_ROOT,
        ST_GATE,
        ST_MSQ,
        ST_SUM,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

>>> rtl/vmr_sample_if.sv
// Sample channel: one 3-axis accelerometer sample per transfer.
// Depends on vmr_pkg for the field widths.
`timescale 1ns / 1ps

interface vmr_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [vmr_pkg::ACCEL_W-1:0]  accel_x;
    logic signed [vmr_pkg::ACCEL_W-1:0]  accel_y;
    logic signed [vmr_pkg::ACCEL_W-1:0]  accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

>>> rtl/vmr_result_if.sv
// Result channel: gated magnitude and window RMS, one transfer per sample.
// Depends on vmr_pkg for the field widths.
`timescale 1ns / 1ps

interface vmr_result_if;
    logic                        valid;
    logic                        ready;
    logic [vmr_pkg::MAG_W-1:0]   magnitude;
    logic                        window_done;
    logic [vmr_pkg::MAG_W-1:0]   window_rms;

    modport source (output valid, output magnitude, output window_done, output window_rms,
                    input ready);
    modport sink   (input valid, input magnitude, input window_done, input window_rms,
                    output ready);
endinterface

>>> rtl/vibration_magnitude_rms_core.sv
// Top level of the vibration magnitude RMS core: digit-serial squaring, root and division.
// Depends on vmr_pkg, vmr_sample_if and vmr_result_if.
`timescale 1ns / 1ps

//  channel     dir   handshake      payload
//  sample_ch   in    valid/ready    accel_x, accel_y, accel_z (16 bit signed)
//  result_ch   out   valid/ready    magnitude (21), window_done (1), window_rms (21)
//  cfg         in    cfg_we         cfg_index (2), cfg_data (21)
//
//  One sample at a time; the pace is set by the serial squarer (4 bits a step) and the
//  23-step square root. The sample that closes a window adds 46 division steps and a
//  second 23-step root. Results sit in an output register, so the next sample is taken
//  while the previous result waits; a stalled output holds the controller in its last
//  state only once a second result is ready. Reset clears the sum, the counter and
//  the registers to their defaults at once; no clearing pass.

module vibration_magnitude_rms_core #(
    parameter int WINDOW = vmr_pkg::WINDOW_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [vmr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vmr_pkg::CFG_DATA_W-1:0]     cfg_data,
    vmr_sample_if.sink                         sample_ch,
    vmr_result_if.source                       result_ch
);

    localparam int CNT_W = $clog2(WINDOW);
    localparam int REM_W = $clog2(WINDOW) + 1;

    localparam int DIFF_W   = vmr_pkg::DIFF_W;
    localparam int ACC_W    = vmr_pkg::ACC_W;
    localparam int MUL_W    = vmr_pkg::MUL_W;
    localparam int DIGIT_W  = vmr_pkg::DIGIT_W;
    localparam int ROOT_W   = vmr_pkg::ROOT_W;
    localparam int RAD_W    = vmr_pkg::RAD_W;
    localparam int SUM_W    = vmr_pkg::SUM_W;
    localparam int MAG_W    = vmr_pkg::MAG_W;
    localparam int ENERGY_W = vmr_pkg::ENERGY_W;
    localparam int STEP_W   = vmr_pkg::STEP_W;
    localparam int OFFSET_W = vmr_pkg::OFFSET_W;
    localparam int ACCEL_W  = vmr_pkg::ACCEL_W;

    // Offset-corrected absolute difference of one axis: sample * 16 - offset.
    function automatic logic [DIFF_W-1:0] abs_diff(
        input logic [ACCEL_W-1:0]  s,
        input logic [OFFSET_W-1:0] o
    );
        logic [DIFF_W-1:0] d;
        d = {s[ACCEL_W-1], s, 4'b0000} - {o[OFFSET_W-1], o};
        return d[DIFF_W-1] ? (~d + DIFF_W'(1)) : d;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [OFFSET_W-1:0] offx_reg, offy_reg, offz_reg;
    logic [MAG_W-1:0]    floor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offx_reg  <= '0;
            offy_reg  <= '0;
            offz_reg  <= '0;
            floor_reg <= vmr_pkg::NOISE_FLOOR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                vmr_pkg::CFG_OFFSET_X:    offx_reg  <= cfg_data[OFFSET_W-1:0];
                vmr_pkg::CFG_OFFSET_Y:    offy_reg  <= cfg_data[OFFSET_W-1:0];
                vmr_pkg::CFG_OFFSET_Z:    offz_reg  <= cfg_data[OFFSET_W-1:0];
                vmr_pkg::CFG_NOISE_FLOOR: floor_reg <= cfg_data[MAG_W-1:0];
                default:                  floor_reg <= floor_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Controller and datapath registers
    // ------------------------------------------------------------------
    vmr_pkg::state_t state_reg, state_next;

    logic [STEP_W-1:0]   step_reg, step_next;
    logic [1:0]          axis_reg, axis_next;
    logic [ACCEL_W-1:0]  sy_reg, sy_next, sz_reg, sz_next;
    logic [DIFF_W-1:0]   mcand_reg, mcand_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [ENERGY_W-1:0] energy_reg, energy_next;
    logic [RAD_W-1:0]    rad_reg, rad_next;
    logic [ROOT_W-1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [MAG_W-1:0]    mag_reg, mag_next;
    logic [MAG_W-1:0]    rms_reg, rms_next;
    logic                win_reg, win_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [SUM_W-1:0]    div_reg, div_next;
    logic [REM_W-2:0]    drem_reg, drem_next;

    logic                out_valid_reg, out_valid_next;
    logic [MAG_W-1:0]    out_mag_reg, out_mag_next;
    logic                out_done_reg, out_done_next;
    logic [MAG_W-1:0]    out_rms_reg, out_rms_next;

    logic                accept;
    logic                out_load;
    logic                mul_last, root_last, div_last, win_close;

    // Serial squarer step: add mcand times the low digit, shift right one digit
    logic [DIFF_W+DIGIT_W-1:0] mul_pp, mul_sum;
    logic [ACC_W-1:0]          mul_acc;

    // Root step: bring in two radicand bits, try to subtract 4*root+1
    logic [ROOT_W+1:0] rt_rem_sh, rt_trial, rt_rem_sub;
    logic              rt_ge;
    logic [ROOT_W-1:0] rt_root;

    // Division step by WINDOW
    logic [REM_W-1:0] dv_sh;
    logic [REM_W-1:0] dv_rem;
    logic             dv_ge;

    logic [SUM_W:0]   sum_wide;
    logic [SUM_W-1:0] sum_sat;
    logic [MAG_W-1:0] mag_gated;

    assign accept    = sample_ch.valid && sample_ch.ready;
    assign out_load  = (state_reg == vmr_pkg::ST_DONE) && (!out_valid_reg || result_ch.ready);
    assign mul_last  = step_reg == STEP_W'(vmr_pkg::MUL_STEPS - 1);
    assign root_last = step_reg == STEP_W'(ROOT_W - 1);
    assign div_last  = step_reg == STEP_W'(SUM_W - 1);
    assign win_close = count_reg == CNT_W'(WINDOW - 1);

    always_comb
    begin
        mul_pp  = {{DIGIT_W{1'b0}}, mcand_reg} * {{DIFF_W{1'b0}}, acc_reg[DIGIT_W-1:0]};
        mul_sum = {{DIGIT_W{1'b0}}, acc_reg[ACC_W-1:MUL_W]} + mul_pp;
        mul_acc = {mul_sum, acc_reg[MUL_W-1:DIGIT_W]};
    end

    always_comb
    begin
        rt_rem_sh  = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
        rt_trial   = {1'b0, root_reg[ROOT_W-2:0], 2'b01};
        rt_ge      = rt_rem_sh >= rt_trial;
        rt_rem_sub = rt_rem_sh - rt_trial;
        rt_root    = {root_reg[ROOT_W-2:0], rt_ge};
    end

    always_comb
    begin
        dv_sh  = {drem_reg, div_reg[SUM_W-1]};
        dv_ge  = dv_sh >= REM_W'(WINDOW);
        dv_rem = dv_ge ? (dv_sh - REM_W'(WINDOW)) : dv_sh;
    end

    always_comb
    begin
        sum_wide  = {1'b0, sum_reg} + {{(SUM_W + 1 - ENERGY_W){1'b0}}, acc_reg[ENERGY_W-1:0]};
        sum_sat   = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
        mag_gated = (mag_reg < floor_reg) ? '0 : mag_reg;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vmr_pkg::ST_IDLE: if (accept) state_next = vmr_pkg::ST_SQ;
            vmr_pkg::ST_SQ:   if (mul_last) state_next = vmr_pkg::ST_ACC;
            vmr_pkg::ST_ACC:  state_next = (axis_reg == 2'd2) ? vmr_pkg::ST_ROOT
                                                               : vmr_pkg::ST_SQ;
            vmr_pkg::ST_ROOT:
            begin
                if (root_last) state_next = win_reg ? vmr_pkg::ST_DONE : vmr_pkg::ST_GATE;
            end
            vmr_pkg::ST_GATE: state_next = vmr_pkg::ST_MSQ;
            vmr_pkg::ST_MSQ:  if (mul_last) state_next = vmr_pkg::ST_SUM;
            vmr_pkg::ST_SUM:  state_next = win_close ? vmr_pkg::ST_DIV : vmr_pkg::ST_DONE;
            vmr_pkg::ST_DIV:  if (div_last) state_next = vmr_pkg::ST_ROOT;
            vmr_pkg::ST_DONE: if (out_load) state_next = vmr_pkg::ST_IDLE;
            default:          state_next = vmr_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        step_next   = step_reg + STEP_W'(1);
        axis_next   = axis_reg;
        sy_next     = sy_reg;
        sz_next     = sz_reg;
        mcand_next  = mcand_reg;
        acc_next    = acc_reg;
        energy_next = energy_reg;
        rad_next    = rad_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        mag_next    = mag_reg;
        rms_next    = rms_reg;
        win_next    = win_reg;
        sum_next    = sum_reg;
        count_next  = count_reg;
        div_next    = div_reg;
        drem_next   = drem_reg;

        unique case (state_reg) inside
            vmr_pkg::ST_IDLE:
            begin
                // Load x straight from the port; hold y and z for later
                step_next   = '0;
                axis_next   = 2'd0;
                sy_next     = sample_ch.accel_y;
                sz_next     = sample_ch.accel_z;
                mcand_next  = abs_diff(sample_ch.accel_x, offx_reg);
                acc_next    = ACC_W'(abs_diff(sample_ch.accel_x, offx_reg));
                energy_next = '0;
                win_next    = 1'b0;
                rms_next    = '0;
            end
            vmr_pkg::ST_SQ, vmr_pkg::ST_MSQ:
            begin
                acc_next = mul_acc;
            end
            vmr_pkg::ST_ACC:
            begin
                energy_next = energy_reg + acc_reg[ENERGY_W-1:0];
                step_next   = '0;
                axis_next   = axis_reg + 2'd1;
                if (axis_reg == 2'd0)
                begin
                    mcand_next = abs_diff(sy_reg, offy_reg);
                    acc_next   = ACC_W'(abs_diff(sy_reg, offy_reg));
                end
                else
                begin
                    mcand_next = abs_diff(sz_reg, offz_reg);
                    acc_next   = ACC_W'(abs_diff(sz_reg, offz_reg));
                end
                rad_next  = RAD_W'(energy_reg + acc_reg[ENERGY_W-1:0]);
                rem_next  = '0;
                root_next = '0;
            end
            vmr_pkg::ST_ROOT:
            begin
                rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
                rem_next  = rt_ge ? rt_rem_sub[ROOT_W-1:0] : rt_rem_sh[ROOT_W-1:0];
                root_next = rt_root;
                if (root_last)
                begin
                    if (win_reg)
                        rms_next = rt_root[MAG_W-1:0];
                    else
                        mag_next = rt_root[MAG_W-1:0];
                end
            end
            vmr_pkg::ST_GATE:
            begin
                step_next  = '0;
                mag_next   = mag_gated;
                mcand_next = mag_gated;
                acc_next   = ACC_W'(mag_gated);
            end
            vmr_pkg::ST_SUM:
            begin
                step_next = '0;
                if (win_close)
                begin
                    // Hand the closed window to the divider and start a fresh one
                    win_next   = 1'b1;
                    div_next   = sum_sat;
                    drem_next  = '0;
                    sum_next   = '0;
                    count_next = '0;
                end
                else
                begin
                    sum_next   = sum_sat;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            vmr_pkg::ST_DIV:
            begin
                div_next  = {div_reg[SUM_W-2:0], dv_ge};
                drem_next = dv_rem[REM_W-2:0];
                if (div_last)
                begin
                    step_next = '0;
                    rad_next  = {div_reg[SUM_W-2:0], dv_ge};
                    rem_next  = '0;
                    root_next = '0;
                end
            end
            vmr_pkg::ST_DONE:
            begin
                step_next = step_reg;
            end
            default:
            begin
                step_next = step_reg;
            end
        endcase
    end

    // Output register: load on completion, drop once transferred
    always_comb
    begin
        out_mag_next  = out_mag_reg;
        out_done_next = out_done_reg;
        out_rms_next  = out_rms_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_mag_next   = mag_reg;
            out_done_next  = win_reg;
            out_rms_next   = rms_reg;
        end
        else if (result_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign sample_ch.ready       = state_reg == vmr_pkg::ST_IDLE;
    assign result_ch.valid       = out_valid_reg;
    assign result_ch.magnitude   = out_mag_reg;
    assign result_ch.window_done = out_done_reg;
    assign result_ch.window_rms  = out_rms_reg;

    // Control state: cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vmr_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
            count_reg     <= '0;
            win_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            win_reg       <= win_next;
        end
    end

    // Payload: no reset needed
    always_ff @(posedge clk)
    begin
        step_reg     <= step_next;
        axis_reg     <= axis_next;
        sy_reg       <= sy_next;
        sz_reg       <= sz_next;
        mcand_reg    <= mcand_next;
        acc_reg      <= acc_next;
        energy_reg   <= energy_next;
        rad_reg      <= rad_next;
        rem_reg      <= rem_next;
        root_reg     <= root_next;
        mag_reg      <= mag_next;
        rms_reg      <= rms_next;
        div_reg      <= div_next;
        drem_reg     <= drem_next;
        out_mag_reg  <= out_mag_next;
        out_done_reg <= out_done_next;
        out_rms_reg  <= out_rms_next;
    end

endmodule

>>> sim/tb_vibration_magnitude_rms_core.sv
// Testbench for vibration_magnitude_rms_core: directed and random accelerometer samples,
// checked against a local magnitude and windowed RMS predictor.
// Depends on rtl/vmr_pkg.sv, rtl/vmr_sample_if.sv, rtl/vmr_result_if.sv and the core.
`timescale 1ns / 1ps

module tb_vibration_magnitude_rms_core;

    import vmr_pkg::*;

    localparam int WINDOW = WINDOW_DEFAULT;
    localparam longint unsigned SUM_MAX = (64'd1 << SUM_W) - 64'd1;
    localparam int MAX_REPORTS = 10;

    // Random traffic: three idling profiles, each split into segments with fresh settings
    localparam int SEGMENTS      = 6;
    localparam int SEGMENT_ITEMS = 86;

    // Settle time once the result queue is empty; longer than a window-closing sample takes
    localparam int TAIL_CYCLES = 130;

    localparam logic signed [ACCEL_W-1:0] ACCEL_MAX = 16'sh7FFF;
    localparam logic signed [ACCEL_W-1:0] ACCEL_MIN = -16'sh8000;

    // Offset register values: bit 20 lies above the 20-bit register and must be dropped
    localparam logic [CFG_DATA_W-1:0] OFFSET_MAX_RAW = 21'h07_FFFF;
    localparam logic [CFG_DATA_W-1:0] OFFSET_MIN_RAW = 21'h08_0000;
    localparam logic [CFG_DATA_W-1:0] OFFSET_MAX_DIRTY = 21'h17_FFFF;
    localparam logic [CFG_DATA_W-1:0] ZERO_DIRTY = 21'h10_0000;
    localparam logic [CFG_DATA_W-1:0] FLOOR_MAX = 21'h1F_FFFF;

    typedef struct {
        logic [MAG_W-1:0] magnitude;
        logic             window_done;
        logic [MAG_W-1:0] window_rms;
    } rms_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    vmr_sample_if sample_ch ();
    vmr_result_if result_ch ();

    vibration_magnitude_rms_core #(
        .WINDOW (WINDOW)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample_ch (sample_ch),
        .result_ch (result_ch)
    );

    // Predictor copy of the calibration registers and the window accumulator
    logic signed [OFFSET_W-1:0] cal_offset_x;
    logic signed [OFFSET_W-1:0] cal_offset_y;
    logic signed [OFFSET_W-1:0] cal_offset_z;
    logic [MAG_W-1:0]           gate_level;
    logic [SUM_W-1:0]           window_energy;
    int                         window_fill;

    // Expected results, oldest first
    rms_result_t results_due[$];

    int src_idle_pct;
    int sink_idle_pct;

    int mismatches;
    int samples_sent;
    int results_seen;
    int windows_closed;
    int gated_to_zero;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop: far beyond the slowest legal run of all the traffic below
    initial
    begin
        #40_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Floor of the square root, built one root bit at a time from the top
    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int i = 23; i >= 0; i--)
        begin
            trial = root | (64'd1 << i);
            if (trial * trial <= n)
                root = trial;
        end
        return root;
    endfunction

    // Advance the predictor by one sample and return the result it must produce
    function automatic rms_result_t next_rms_result(input logic signed [ACCEL_W-1:0] ax,
                                                    input logic signed [ACCEL_W-1:0] ay,
                                                    input logic signed [ACCEL_W-1:0] az);
        longint          dx;
        longint          dy;
        longint          dz;
        longint unsigned energy;
        longint unsigned mag;
        longint unsigned sq;
        rms_result_t     res;

        // Scale each axis to 1/16 LSB and remove its zero offset
        dx = longint'(ax) * 16 - longint'(cal_offset_x);
        dy = longint'(ay) * 16 - longint'(cal_offset_y);
        dz = longint'(az) * 16 - longint'(cal_offset_z);
        energy = dx * dx + dy * dy + dz * dz;
        mag = floor_sqrt(energy);

        // A magnitude equal to the floor passes; only one below it is dropped
        if (mag < gate_level)
            mag = 0;
        if (mag == 0)
            gated_to_zero++;

        // Saturate the running sum rather than wrap it
        sq = mag * mag;
        if (sq > SUM_MAX - window_energy)
            window_energy = SUM_W'(SUM_MAX);
        else
            window_energy = SUM_W'(window_energy + sq);

        res.magnitude   = MAG_W'(mag);
        res.window_done = 1'b0;
        res.window_rms  = '0;

        window_fill++;
        if (window_fill >= WINDOW)
        begin
            res.window_rms  = MAG_W'(floor_sqrt(window_energy / WINDOW));
            res.window_done = 1'b1;
            window_energy   = '0;
            window_fill     = 0;
            windows_closed++;
        end
        return res;
    endfunction

    // Offer one sample, idling beforehand at the current sender rate, and record the
    // expected result at the edge where the transfer happens. Returns just after a
    // falling edge with valid still high, so a following sample keeps it high.
    task automatic send_sample(input logic signed [ACCEL_W-1:0] ax,
                               input logic signed [ACCEL_W-1:0] ay,
                               input logic signed [ACCEL_W-1:0] az);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(negedge clk);
        end
        sample_ch.valid   <= 1'b1;
        sample_ch.accel_x <= ax;
        sample_ch.accel_y <= ay;
        sample_ch.accel_z <= az;
        do
        begin
            @(posedge clk);
        end
        while (!sample_ch.ready);
        results_due.push_back(next_rms_result(ax, ay, az));
        samples_sent++;
        @(negedge clk);
    endtask

    // Drop valid and hold off until every expected result has been taken
    task automatic wait_for_results();
        sample_ch.valid <= 1'b0;
        while (results_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // One register write; the predictor keeps only the bits the register holds
    task automatic write_register(input logic [CFG_IDX_W-1:0]  idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        case (idx)
            CFG_OFFSET_X:    cal_offset_x = data[OFFSET_W-1:0];
            CFG_OFFSET_Y:    cal_offset_y = data[OFFSET_W-1:0];
            CFG_OFFSET_Z:    cal_offset_z = data[OFFSET_W-1:0];
            CFG_NOISE_FLOOR: gate_level   = data[MAG_W-1:0];
            default:         ;
        endcase
    endtask

    task automatic set_calibration(input logic [CFG_DATA_W-1:0] ox,
                                   input logic [CFG_DATA_W-1:0] oy,
                                   input logic [CFG_DATA_W-1:0] oz,
                                   input logic [CFG_DATA_W-1:0] floor_level);
        write_register(CFG_OFFSET_X, ox);
        write_register(CFG_OFFSET_Y, oy);
        write_register(CFG_OFFSET_Z, oz);
        write_register(CFG_NOISE_FLOOR, floor_level);
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_offset();
        int                    pick;
        logic [CFG_DATA_W-1:0] v;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            v = CFG_DATA_W'($urandom);              // bit 20 set at random too
        else if (pick < 80)
            v = CFG_DATA_W'($urandom_range(0, 10000) - 5000);
        else
        begin
            case ($urandom_range(0, 2))
                0:       v = OFFSET_MIN_RAW;
                1:       v = OFFSET_MAX_RAW;
                default: v = ZERO_DIRTY;
            endcase
        end
        return v;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_floor();
        int                    pick;
        logic [CFG_DATA_W-1:0] v;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            v = '0;
        else if (pick < 30)
            v = NOISE_FLOOR_RESET;
        else if (pick < 60)
            v = CFG_DATA_W'($urandom_range(0, 1500));
        else if (pick < 80)
            v = CFG_DATA_W'($urandom_range(0, 200000));
        else if (pick < 90)
            v = CFG_DATA_W'($urandom);
        else
            v = FLOOR_MAX;
        return v;
    endfunction

    // A raw sample within 64 LSB of the axis offset, so magnitudes land near the floor
    function automatic logic signed [ACCEL_W-1:0] near_offset(
        input logic signed [OFFSET_W-1:0] off);
        longint v;
        v = (longint'(off) >>> 4) + longint'($urandom_range(0, 128)) - 64;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return ACCEL_W'(v);
    endfunction

    function automatic logic signed [ACCEL_W-1:0] extreme_accel();
        case ($urandom_range(0, 4))
            0:       return ACCEL_MIN;
            1:       return ACCEL_MAX;
            2:       return 16'sd0;
            3:       return -16'sd1;
            default: return 16'sd1;
        endcase
    endfunction

    task automatic send_random_sample();
        logic signed [ACCEL_W-1:0] ax;
        logic signed [ACCEL_W-1:0] ay;
        logic signed [ACCEL_W-1:0] az;
        int                        pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            ax = ACCEL_W'($urandom);
            ay = ACCEL_W'($urandom);
            az = ACCEL_W'($urandom);
        end
        else if (pick < 75)
        begin
            ax = near_offset(cal_offset_x);
            ay = near_offset(cal_offset_y);
            az = near_offset(cal_offset_z);
        end
        else
        begin
            ax = extreme_accel();
            ay = extreme_accel();
            az = extreme_accel();
        end
        send_sample(ax, ay, az);
    endtask

    // Reset values: zero offsets and the default floor of 123
    task automatic test_reset_defaults();
        send_sample(16'sd0, 16'sd0, 16'sd0);
        send_sample(16'sd7, 16'sd0, 16'sd0);        // 112, under the default floor
        send_sample(16'sd0, -16'sd8, 16'sd0);       // 128, passes
    endtask

    // Gate: a magnitude at the floor passes, one below is zeroed
    task automatic test_noise_gate();
        wait_for_results();
        set_calibration('0, '0, '0, 21'd1600);
        send_sample(16'sd100, 16'sd0, 16'sd0);
        send_sample(16'sd0, -16'sd100, 16'sd0);
        send_sample(16'sd99, 16'sd0, 16'sd0);
        wait_for_results();
        write_register(CFG_NOISE_FLOOR, 21'd1601);
        send_sample(16'sd0, 16'sd0, 16'sd100);
        wait_for_results();
        write_register(CFG_NOISE_FLOOR, '0);
        send_sample(16'sd0, 16'sd0, 16'sd0);
        send_sample(16'sd0, 16'sd0, 16'sd1);
    endtask

    // Largest differences in both directions, stray bit 20 on offsets, floor at maximum
    task automatic test_field_extremes();
        wait_for_results();
        set_calibration('0, '0, '0, '0);
        send_sample(ACCEL_MAX, ACCEL_MAX, ACCEL_MAX);
        send_sample(ACCEL_MIN, ACCEL_MIN, ACCEL_MIN);
        send_sample(ACCEL_MIN, ACCEL_MAX, 16'sd0);
        wait_for_results();
        set_calibration(OFFSET_MAX_DIRTY, OFFSET_MAX_RAW, OFFSET_MAX_DIRTY, '0);
        send_sample(ACCEL_MIN, ACCEL_MIN, ACCEL_MIN);
        wait_for_results();
        set_calibration(OFFSET_MIN_RAW, OFFSET_MIN_RAW, OFFSET_MIN_RAW, '0);
        send_sample(ACCEL_MAX, ACCEL_MAX, ACCEL_MAX);
        wait_for_results();
        write_register(CFG_NOISE_FLOOR, FLOOR_MAX);
        send_sample(ACCEL_MAX, ACCEL_MIN, ACCEL_MAX);
    endtask

    // Close the current window with the largest magnitude the fields allow
    task automatic test_window_close();
        wait_for_results();
        set_calibration(OFFSET_MAX_RAW, OFFSET_MAX_RAW, OFFSET_MAX_RAW, '0);
        do
        begin
            send_sample(ACCEL_MIN, ACCEL_MIN, ACCEL_MIN);
        end
        while (window_fill != 0);
    endtask

    // Random samples under a fresh calibration per segment; the block drains before
    // every change, which also gives the pause with no samples offered
    task automatic test_random_traffic(input int profile);
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            wait_for_results();
            if (seg == 0 && profile == 0)
                set_calibration('0, '0, '0, NOISE_FLOOR_RESET);
            else if (seg == 0 && profile == 1)
                set_calibration(OFFSET_MIN_RAW, OFFSET_MIN_RAW, OFFSET_MIN_RAW, '0);
            else if (seg == 0)
                set_calibration(OFFSET_MAX_RAW, OFFSET_MAX_RAW, OFFSET_MAX_RAW, '0);
            else
                set_calibration(random_offset(), random_offset(), random_offset(),
                                random_floor());
            for (int n = 0; n < SEGMENT_ITEMS; n++)
                send_random_sample();
        end
    endtask

    // Receiver: drop ready at random at the current sink rate
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Compare every result transfer with the oldest expectation
    always @(posedge clk)
    begin : check_results
        rms_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            results_seen++;
            if (results_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: magnitude %0d done %0b rms %0d",
                             result_ch.magnitude, result_ch.window_done,
                             result_ch.window_rms);
            end
            else
            begin
                want = results_due.pop_front();
                if (result_ch.magnitude !== want.magnitude ||
                    result_ch.window_done !== want.window_done ||
                    result_ch.window_rms !== want.window_rms)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("mismatch at result %0d: expected mag %0d done %0b rms %0d",
                                 results_seen, want.magnitude, want.window_done,
                                 want.window_rms);
                        $display("    got mag %0d done %0b rms %0d",
                                 result_ch.magnitude, result_ch.window_done,
                                 result_ch.window_rms);
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        sample_ch.valid   = 1'b0;
        sample_ch.accel_x = '0;
        sample_ch.accel_y = '0;
        sample_ch.accel_z = '0;

        cal_offset_x  = '0;
        cal_offset_y  = '0;
        cal_offset_z  = '0;
        gate_level    = NOISE_FLOOR_RESET;
        window_energy = '0;
        window_fill   = 0;

        mismatches     = 0;
        samples_sent   = 0;
        results_seen   = 0;
        windows_closed = 0;
        gated_to_zero  = 0;

        src_idle_pct  = 34;
        sink_idle_pct = 78;

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_noise_gate();
        test_field_extremes();
        test_window_close();

        // Fast sender with a slow receiver, then swapped, then back to back
        test_random_traffic(0);
        src_idle_pct  = 78;
        sink_idle_pct = 34;
        test_random_traffic(1);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_traffic(2);

        wait_for_results();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("run covered %0d samples and %0d results, %0d RMS windows closed,",
                 samples_sent, results_seen, windows_closed);
        $display("%0d magnitudes gated to zero, %0d mismatches", gated_to_zero, mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
